// ===== hdl/great_circle_distance_bearing_unit_assert.svh =====
// Assertion macros shared by the checker of the great circle distance and bearing unit
`ifndef GREAT_CIRCLE_DISTANCE_BEARING_UNIT_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_BEARING_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define GCDB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gcdb assertion failed");

// next-cycle implication, off during reset
`define GCDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gcdb assertion failed");

// next-cycle implication, checked also across reset
`define GCDB_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("gcdb assertion failed");

`endif

// ===== hdl/gcdb_pkg.sv =====
// Package of the great circle distance and bearing unit: widths, constants, types, helpers
package gcdb_pkg;

    localparam int ANGLE_BITS = 32;
    localparam int UP_SH      = (ANGLE_BITS >= 32) ? (ANGLE_BITS - 32) : 0;
    localparam int DN_SH      = (ANGLE_BITS >= 32) ? 0 : (32 - ANGLE_BITS);
    localparam int Z_W        = ANGLE_BITS + 1;
    localparam int NSTEPS     = 31;
    localparam int XY_W       = 44;
    localparam int Q_W        = 34;
    localparam int NORM_BITS  = 40;
    localparam int M_W        = NORM_BITS + 1;
    localparam int N_SHIFTS   = 6;
    localparam int A_W        = 31;
    localparam int SQ_STEPS   = 31;
    localparam int SQ_W       = 62;
    localparam int RADIUS_W   = 22;
    localparam int NM_W       = 22;
    localparam int KM_W       = 23;

    localparam logic [XY_W-1:0]     CGAIN         = XY_W'(652032874);
    localparam logic [31:0]         TWO_PI_Q29    = 32'd3373259426;
    localparam logic [RADIUS_W-1:0] RADIUS_NM_RST = 22'd880657;
    localparam logic [RADIUS_W-1:0] RADIUS_KM_RST = 22'd1630976;
    localparam logic [NM_W-1:0]     NM_MAX        = 22'd4194303;
    localparam logic [KM_W-1:0]     KM_MAX        = 23'd8388607;

    typedef enum logic [0:0] {
        REG_RADIUS_NM = 1'b0,
        REG_RADIUS_KM = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] from_lat;
        logic signed [31:0] from_lon;
        logic signed [31:0] to_lat;
        logic signed [31:0] to_lon;
    } t_in;

    typedef struct packed {
        logic [NM_W-1:0] dist_nm_q8;
        logic [KM_W-1:0] dist_km_q8;
        logic [31:0]     bearing_fwd;
        logic [31:0]     bearing_back;
    } t_out;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

    function automatic logic [31:0] atan_turn32(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            24:      v = 32'd41;
            25:      v = 32'd20;
            26:      v = 32'd10;
            27:      v = 32'd5;
            28:      v = 32'd3;
            29:      v = 32'd1;
            30:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [Z_W-1:0] atan_step(input int i);
        logic [ANGLE_BITS+31:0] t;
        t = {{ANGLE_BITS{1'b0}}, atan_turn32(i)};
        t = t << UP_SH;
        t = (t + (((ANGLE_BITS+32)'(1) << DN_SH) >> 1)) >> DN_SH;
        return Z_W'(t);
    endfunction

    function automatic logic [ANGLE_BITS-1:0] from32(input logic [31:0] v);
        logic [ANGLE_BITS+31:0] w;
        w = {{ANGLE_BITS{1'b0}}, v};
        w = (w << UP_SH) >> DN_SH;
        return w[ANGLE_BITS-1:0];
    endfunction

    function automatic logic [31:0] to32(input logic [ANGLE_BITS-1:0] v);
        logic [ANGLE_BITS+31:0] w;
        w = {32'd0, v};
        w = (w << DN_SH) >> UP_SH;
        return w[31:0];
    endfunction

endpackage

// ===== hdl/great_circle_distance_bearing_unit.sv =====
// Top level of the great circle distance and bearing unit (haversine, pipelined CORDIC)
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_in (t_in)     | sink
//  out     | o_out_valid, i_out_ready, o_out (t_out) | source
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_wdata      | sink
//
// One transfer per cycle in steady state while the output is not stalled; the pipeline has two
// 31-stage CORDIC chains and a 31-stage square root chain in series.
// Synchronous active-low reset clears the valid chain and presets the radius registers.
// A stalled output freezes the whole pipeline; bubbles keep moving while the output is empty.
module great_circle_distance_bearing_unit import gcdb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in                 i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out                o_out,
    input  logic                i_cfg_we,
    input  t_reg_idx            i_cfg_index,
    input  logic [RADIUS_W-1:0] i_cfg_wdata
);

    localparam int LAT = 2 * NSTEPS + SQ_STEPS + N_SHIFTS + 13;
    localparam int NU_ROT = 6;
    localparam int NU_VEC = 3;
    localparam int U_LAT1 = 0;
    localparam int U_LAT2 = 1;
    localparam int U_HLAT = 2;
    localparam int U_HLON = 3;
    localparam int U_DLON = 4;
    localparam int U_RLON = 5;
    localparam int U_DIST = 0;
    localparam int U_FWD  = 1;
    localparam int U_BACK = 2;
    localparam int B_FY   = 0;
    localparam int B_FX   = 1;
    localparam int B_BY   = 2;
    localparam int B_BX   = 3;

    localparam logic signed [Z_W-1:0] AQUART = Z_W'(1) << (ANGLE_BITS - 2);
    localparam logic signed [Z_W-1:0] HALF_T = Z_W'(1) << (ANGLE_BITS - 1);
    localparam logic signed [ANGLE_BITS-1:0] AQ_A = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic signed [2*Q_W-1:0] MUL_RND = (2*Q_W)'(1) << 29;
    localparam logic signed [Q_W:0] ONE_S = (Q_W+1)'(1) << 30;
    localparam logic [A_W-1:0] ONE_Q30 = A_W'(1) << 30;

    function automatic logic signed [Q_W-1:0] mulq(input logic signed [Q_W-1:0] p,
                                                   input logic signed [Q_W-1:0] q);
        logic signed [2*Q_W-1:0] w;
        w = p * q + MUL_RND;
        return Q_W'(w >>> 30);
    endfunction

    logic w_en;
    logic [LAT-1:0] r_vld;
    logic [RADIUS_W-1:0] r_radius_nm;
    logic [RADIUS_W-1:0] r_radius_km;

    assign w_en        = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_nm <= RADIUS_NM_RST;
            r_radius_km <= RADIUS_KM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RADIUS_NM: r_radius_nm <= i_cfg_wdata;
                REG_RADIUS_KM: r_radius_km <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage A: latitudes, angle differences and half differences
    logic [ANGLE_BITS-1:0] n_a_ang [NU_ROT];
    logic [ANGLE_BITS-1:0] r_a_ang [NU_ROT];
    logic [ANGLE_BITS-1:0] w_lat1, w_lon1, w_lat2, w_lon2, w_dlat, w_dlon;

    always_comb begin
        w_lat1 = from32(i_in.from_lat);
        w_lon1 = from32(i_in.from_lon);
        w_lat2 = from32(i_in.to_lat);
        w_lon2 = from32(i_in.to_lon);
        w_dlat = w_lat2 - w_lat1;
        w_dlon = w_lon2 - w_lon1;
        n_a_ang[U_LAT1] = w_lat1;
        n_a_ang[U_LAT2] = w_lat2;
        n_a_ang[U_HLAT] = {w_dlat[ANGLE_BITS-1], w_dlat[ANGLE_BITS-1:1]};
        n_a_ang[U_HLON] = {w_dlon[ANGLE_BITS-1], w_dlon[ANGLE_BITS-1:1]};
        n_a_ang[U_DLON] = w_dlon;
        n_a_ang[U_RLON] = w_lon1 - w_lon2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ang <= n_a_ang;
        end
    end

    // stage A2: fold into [-90, 90] degrees
    logic signed [Z_W-1:0] n_a2_z [NU_ROT];
    logic signed [Z_W-1:0] r_a2_z [NU_ROT];
    logic [NU_ROT-1:0]     n_a2_neg;
    logic [NU_ROT-1:0]     r_a2_neg;

    always_comb begin
        for (int u = 0; u < NU_ROT; u++) begin
            n_a2_z[u]   = Z_W'($signed(r_a_ang[u]));
            n_a2_neg[u] = 1'b0;
            if (n_a2_z[u] > AQUART) begin
                n_a2_z[u]   = n_a2_z[u] - HALF_T;
                n_a2_neg[u] = 1'b1;
            end else if (n_a2_z[u] < -AQUART) begin
                n_a2_z[u]   = n_a2_z[u] + HALF_T;
                n_a2_neg[u] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a2_z   <= n_a2_z;
            r_a2_neg <= n_a2_neg;
        end
    end

    // sine and cosine chains
    t_cordic w_rot_in  [NU_ROT];
    t_cordic w_rot_out [NU_ROT];
    logic [NU_ROT-1:0] r_neg_dly [NSTEPS];

    for (genvar u = 0; u < NU_ROT; u++) begin : g_rot
        assign w_rot_in[u].x = CGAIN;
        assign w_rot_in[u].y = '0;
        assign w_rot_in[u].z = r_a2_z[u];

        gcdb_cordic u_cordic (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_vec (1'b0),
            .i_d   (w_rot_in[u]),
            .o_d   (w_rot_out[u])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg_dly[0] <= r_a2_neg;
            for (int j = 1; j < NSTEPS; j++) begin
                r_neg_dly[j] <= r_neg_dly[j-1];
            end
        end
    end

    // stage B0: undo the fold
    logic signed [Q_W-1:0] r_b0_s [NU_ROT];
    logic signed [Q_W-1:0] r_b0_c [NU_ROT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int u = 0; u < NU_ROT; u++) begin
                if (r_neg_dly[NSTEPS-1][u]) begin
                    r_b0_s[u] <= Q_W'(-w_rot_out[u].y);
                    r_b0_c[u] <= Q_W'(-w_rot_out[u].x);
                end else begin
                    r_b0_s[u] <= Q_W'(w_rot_out[u].y);
                    r_b0_c[u] <= Q_W'(w_rot_out[u].x);
                end
            end
        end
    end

    // stage B: first products
    logic signed [Q_W-1:0] r_b_shl2, r_b_c1c2, r_b_shn2, r_b_fy, r_b_ft1, r_b_fs1c2;
    logic signed [Q_W-1:0] r_b_by, r_b_bt1, r_b_bs2c1, r_b_cd, r_b_cr;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_shl2  <= mulq(r_b0_s[U_HLAT], r_b0_s[U_HLAT]);
            r_b_c1c2  <= mulq(r_b0_c[U_LAT1], r_b0_c[U_LAT2]);
            r_b_shn2  <= mulq(r_b0_s[U_HLON], r_b0_s[U_HLON]);
            r_b_fy    <= mulq(r_b0_s[U_DLON], r_b0_c[U_LAT2]);
            r_b_ft1   <= mulq(r_b0_c[U_LAT1], r_b0_s[U_LAT2]);
            r_b_fs1c2 <= mulq(r_b0_s[U_LAT1], r_b0_c[U_LAT2]);
            r_b_by    <= mulq(r_b0_s[U_RLON], r_b0_c[U_LAT1]);
            r_b_bt1   <= mulq(r_b0_c[U_LAT2], r_b0_s[U_LAT1]);
            r_b_bs2c1 <= mulq(r_b0_s[U_LAT2], r_b0_c[U_LAT1]);
            r_b_cd    <= r_b0_c[U_DLON];
            r_b_cr    <= r_b0_c[U_RLON];
        end
    end

    // stage C: second products
    logic signed [Q_W-1:0] r_c_t2, r_c_fx2, r_c_bx2, r_c_shl2, r_c_fy, r_c_ft1, r_c_by, r_c_bt1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_t2   <= mulq(r_b_c1c2, r_b_shn2);
            r_c_fx2  <= mulq(r_b_fs1c2, r_b_cd);
            r_c_bx2  <= mulq(r_b_bs2c1, r_b_cr);
            r_c_shl2 <= r_b_shl2;
            r_c_fy   <= r_b_fy;
            r_c_ft1  <= r_b_ft1;
            r_c_by   <= r_b_by;
            r_c_bt1  <= r_b_bt1;
        end
    end

    // stage D: haversine term, clamped, and bearing operands
    logic signed [Q_W:0]   w_d_sum;
    logic [A_W-1:0]        n_d_a;
    logic [A_W-1:0]        r_d_a;
    logic signed [Q_W-1:0] r_d_brg [4];

    always_comb begin
        w_d_sum = (Q_W+1)'(r_c_shl2) + (Q_W+1)'(r_c_t2);
        if (w_d_sum < 0) begin
            n_d_a = '0;
        end else if (w_d_sum > ONE_S) begin
            n_d_a = ONE_Q30;
        end else begin
            n_d_a = A_W'(w_d_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_a         <= n_d_a;
            r_d_brg[B_FY] <= r_c_fy;
            r_d_brg[B_FX] <= r_c_ft1 - r_c_fx2;
            r_d_brg[B_BY] <= r_c_by;
            r_d_brg[B_BX] <= r_c_bt1 - r_c_bx2;
        end
    end

    // square roots of a and 1-a, one result bit per stage
    logic [SQ_W-1:0]       w_sq_v0 [2];
    logic [SQ_W-1:0]       r_sq_v  [2][SQ_STEPS];
    logic [SQ_W-1:0]       r_sq_r  [2][SQ_STEPS];
    logic signed [Q_W-1:0] r_brg_dly [SQ_STEPS][4];

    assign w_sq_v0[0] = SQ_W'({r_d_a, 30'd0});
    assign w_sq_v0[1] = SQ_W'({ONE_Q30 - r_d_a, 30'd0});

    for (genvar q = 0; q < 2; q++) begin : g_sq
        for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - s));
            logic [SQ_W-1:0] w_v, w_r, w_t;

            if (s == 0) begin : g_first
                assign w_v = w_sq_v0[q];
                assign w_r = '0;
            end else begin : g_next
                assign w_v = r_sq_v[q][s-1];
                assign w_r = r_sq_r[q][s-1];
            end

            assign w_t = w_r + BIT;

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    if (w_v >= w_t) begin
                        r_sq_v[q][s] <= w_v - w_t;
                        r_sq_r[q][s] <= (w_r >> 1) + BIT;
                    end else begin
                        r_sq_v[q][s] <= w_v;
                        r_sq_r[q][s] <= w_r >> 1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_brg_dly[0] <= r_d_brg;
            for (int j = 1; j < SQ_STEPS; j++) begin
                r_brg_dly[j] <= r_brg_dly[j-1];
            end
        end
    end

    // normalize atan2 operands: N0 magnitude, then binary shift stages, then half turn
    logic signed [XY_W-1:0] w_nx [NU_VEC];
    logic signed [XY_W-1:0] w_ny [NU_VEC];
    logic signed [XY_W-1:0] r_n_x [NU_VEC][N_SHIFTS+1];
    logic signed [XY_W-1:0] r_n_y [NU_VEC][N_SHIFTS+1];
    logic [M_W-1:0]         r_n_m [NU_VEC][N_SHIFTS+1];
    logic [NU_VEC-1:0]      r_n_zero [N_SHIFTS+1];

    always_comb begin
        w_ny[U_DIST] = $signed({{(XY_W-A_W){1'b0}}, r_sq_r[0][SQ_STEPS-1][A_W-1:0]});
        w_nx[U_DIST] = $signed({{(XY_W-A_W){1'b0}}, r_sq_r[1][SQ_STEPS-1][A_W-1:0]});
        w_ny[U_FWD]  = XY_W'(r_brg_dly[SQ_STEPS-1][B_FY]);
        w_nx[U_FWD]  = XY_W'(r_brg_dly[SQ_STEPS-1][B_FX]);
        w_ny[U_BACK] = XY_W'(r_brg_dly[SQ_STEPS-1][B_BY]);
        w_nx[U_BACK] = XY_W'(r_brg_dly[SQ_STEPS-1][B_BX]);
    end

    for (genvar u = 0; u < NU_VEC; u++) begin : g_norm
        logic [XY_W-1:0] w_ax, w_ay, w_m;

        always_comb begin
            w_ax = w_nx[u][XY_W-1] ? XY_W'(-w_nx[u]) : XY_W'(w_nx[u]);
            w_ay = w_ny[u][XY_W-1] ? XY_W'(-w_ny[u]) : XY_W'(w_ny[u]);
            w_m  = (w_ax > w_ay) ? w_ax : w_ay;
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_n_x[u][0]    <= w_nx[u];
                r_n_y[u][0]    <= w_ny[u];
                r_n_m[u][0]    <= M_W'(w_m);
                r_n_zero[0][u] <= (w_m == '0);
            end
        end

        for (genvar j = 1; j <= N_SHIFTS; j++) begin : g_shift
            localparam int SH = 1 << (N_SHIFTS - j);

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_n_zero[j][u] <= r_n_zero[j-1][u];
                    if (~|r_n_m[u][j-1][M_W-1 -: SH]) begin
                        r_n_x[u][j] <= r_n_x[u][j-1] <<< SH;
                        r_n_y[u][j] <= r_n_y[u][j-1] <<< SH;
                        r_n_m[u][j] <= r_n_m[u][j-1] << SH;
                    end else begin
                        r_n_x[u][j] <= r_n_x[u][j-1];
                        r_n_y[u][j] <= r_n_y[u][j-1];
                        r_n_m[u][j] <= r_n_m[u][j-1];
                    end
                end
            end
        end
    end

    t_cordic           r_t_d [NU_VEC];
    logic [NU_VEC-1:0] r_t_zero;
    t_cordic           w_vec_out [NU_VEC];
    logic [NU_VEC-1:0] r_zero_dly [NSTEPS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_zero <= r_n_zero[N_SHIFTS];
            for (int u = 0; u < NU_VEC; u++) begin
                if (r_n_x[u][N_SHIFTS][XY_W-1]) begin
                    r_t_d[u].x <= -r_n_x[u][N_SHIFTS];
                    r_t_d[u].y <= -r_n_y[u][N_SHIFTS];
                    r_t_d[u].z <= HALF_T;
                end else begin
                    r_t_d[u].x <= r_n_x[u][N_SHIFTS];
                    r_t_d[u].y <= r_n_y[u][N_SHIFTS];
                    r_t_d[u].z <= '0;
                end
            end
        end
    end

    for (genvar u = 0; u < NU_VEC; u++) begin : g_vec
        gcdb_cordic u_cordic (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_vec (1'b1),
            .i_d   (r_t_d[u]),
            .o_d   (w_vec_out[u])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero_dly[0] <= r_t_zero;
            for (int j = 1; j < NSTEPS; j++) begin
                r_zero_dly[j] <= r_zero_dly[j-1];
            end
        end
    end

    // P0: central angle and bearings to 32-bit turns
    logic signed [ANGLE_BITS-1:0] w_half;
    logic [ANGLE_BITS-1:0]        w_c;
    logic [NU_VEC-1:0]            w_zero;
    logic [31:0] r_p0_c32, r_p0_bf, r_p0_bb;
    logic [31:0] r_p1_bf, r_p1_bb, r_p2_bf, r_p2_bb, r_p3_bf, r_p3_bb;
    logic [63:0] r_p1_prod;
    logic [32:0] r_p2_rad;
    logic [63:0] w_p2_sum;
    logic [54:0] r_p3_dnm, r_p3_dkm;
    logic [54:0] w_p4_nm, w_p4_km;
    t_out        r_out;

    always_comb begin
        w_zero = r_zero_dly[NSTEPS-1];
        w_half = $signed(w_vec_out[U_DIST].z[ANGLE_BITS-1:0]);
        if (w_zero[U_DIST] || w_half < 0) begin
            w_half = '0;
        end else if (w_half > AQ_A) begin
            w_half = AQ_A;
        end
        w_c = {w_half[ANGLE_BITS-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0_c32 <= to32(w_c);
            r_p0_bf  <= w_zero[U_FWD]  ? 32'd0 : to32(w_vec_out[U_FWD].z[ANGLE_BITS-1:0]);
            r_p0_bb  <= w_zero[U_BACK] ? 32'd0 : to32(w_vec_out[U_BACK].z[ANGLE_BITS-1:0]);
        end
    end

    // P1..P3: radians, then distances
    assign w_p2_sum = r_p1_prod + (64'd1 << 30);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_prod <= 64'(r_p0_c32) * 64'(TWO_PI_Q29);
            r_p1_bf   <= r_p0_bf;
            r_p1_bb   <= r_p0_bb;
            r_p2_rad  <= w_p2_sum[63:31];
            r_p2_bf   <= r_p1_bf;
            r_p2_bb   <= r_p1_bb;
            r_p3_dnm  <= 55'(r_radius_nm) * 55'(r_p2_rad);
            r_p3_dkm  <= 55'(r_radius_km) * 55'(r_p2_rad);
            r_p3_bf   <= r_p2_bf;
            r_p3_bb   <= r_p2_bb;
        end
    end

    // P4: round, saturate, hold for the output transfer
    assign w_p4_nm = (r_p3_dnm + (55'd1 << 29)) >> 30;
    assign w_p4_km = (r_p3_dkm + (55'd1 << 29)) >> 30;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.dist_nm_q8   <= (w_p4_nm > 55'(NM_MAX)) ? NM_MAX : w_p4_nm[NM_W-1:0];
            r_out.dist_km_q8   <= (w_p4_km > 55'(KM_MAX)) ? KM_MAX : w_p4_km[KM_W-1:0];
            r_out.bearing_fwd  <= r_p3_bf;
            r_out.bearing_back <= r_p3_bb;
        end
    end

    assign o_out = r_out;

endmodule

// ===== hdl/gcdb_cordic.sv =====
// Pipelined CORDIC, one micro-rotation per stage, rotation or vectoring mode
module gcdb_cordic import gcdb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  logic    i_vec,
    input  t_cordic i_d,
    output t_cordic o_d
);

    t_cordic r_st [NSTEPS];

    for (genvar i = 0; i < NSTEPS; i++) begin : g_step
        localparam logic signed [Z_W-1:0] STEP = atan_step(i);
        t_cordic w_prev;
        t_cordic n_st;
        logic    w_acw;

        if (i == 0) begin : g_first
            assign w_prev = i_d;
        end else begin : g_next
            assign w_prev = r_st[i-1];
        end

        always_comb begin
            w_acw = i_vec ? !w_prev.y[XY_W-1] : w_prev.z[Z_W-1];
            if (w_acw) begin
                n_st.x = w_prev.x + (w_prev.y >>> i);
                n_st.y = w_prev.y - (w_prev.x >>> i);
                n_st.z = w_prev.z + STEP;
            end else begin
                n_st.x = w_prev.x - (w_prev.y >>> i);
                n_st.y = w_prev.y + (w_prev.x >>> i);
                n_st.z = w_prev.z - STEP;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[i] <= n_st;
            end
        end
    end

    assign o_d = r_st[NSTEPS-1];

endmodule

// ===== hdl/gcdb_chk.sv =====
// Port-level checker of the great circle distance and bearing unit, with its bind
`include "great_circle_distance_bearing_unit_assert.svh"

module gcdb_chk import gcdb_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input t_in                 i_in,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input t_out                o_out,
    input logic                i_cfg_we,
    input t_reg_idx            i_cfg_index,
    input logic [RADIUS_W-1:0] i_cfg_wdata
);

    `GCDB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))
    `GCDB_ASSERT_NOW(a_in_ready, i_clk, i_rst_n, 1'b1, o_in_ready == (!o_out_valid || i_out_ready))
    `GCDB_ASSERT_ALWAYS_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind great_circle_distance_bearing_unit gcdb_chk u_gcdb_chk (.*);

// ===== verif/great_circle_distance_bearing_unit_checker.sv =====
// Checker of the great circle distance and bearing unit: fixed-point predictor and result compare
module great_circle_distance_bearing_unit_checker import gcdb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_in                 i_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_out                i_out,
    input  logic                i_cfg_we,
    input  t_reg_idx            i_cfg_index,
    input  logic [RADIUS_W-1:0] i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint QUARTER   = 64'sd1 << 30;
    localparam longint ONE_Q30   = 64'sd1 << 30;
    localparam longint GAIN_INV  = 64'sd652032874;
    localparam longint NORM_LIM  = 64'sd1 << 40;

    longint      turn_steps [0:30];
    logic [21:0] radius_nm;
    logic [21:0] radius_km;
    t_out        expected_results [$];
    int          fail_count;

    initial begin
        turn_steps = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                       10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                       83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                       81, 41, 20, 10, 5, 3, 1, 1};
    end

    function automatic longint to_signed(input logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint q30_mul(input longint p, input longint q);
        return (p * q + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic void rotate_sincos(input logic [31:0] ang, output longint s,
                                          output longint c);
        longint z, x, y, nx;
        bit     flip;
        z = to_signed(ang);
        x = GAIN_INV;
        y = 0;
        flip = 0;
        if (z > QUARTER) begin
            z -= 2 * QUARTER;
            flip = 1;
        end else if (z < -QUARTER) begin
            z += 2 * QUARTER;
            flip = 1;
        end
        for (int i = 0; i < 31; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= turn_steps[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += turn_steps[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic [31:0] vector_angle(input longint y_in, input longint x_in);
        longint x, y, z, m, nx;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) return 32'd0;
        m = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
        while (m < NORM_LIM) begin
            x *= 2;
            y *= 2;
            m *= 2;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 2 * QUARTER;
        end
        for (int i = 0; i < 31; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += turn_steps[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= turn_steps[i];
            end
            x = nx;
        end
        return z[31:0];
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned scale_radius(input logic [21:0] radius,
                                                     input longint unsigned rad,
                                                     input longint unsigned lim);
        longint unsigned d;
        d = (longint'(radius) * rad + (64'd1 << 29)) >> 30;
        return (d > lim) ? lim : d;
    endfunction

    function automatic t_out predict_leg(input t_in p, input logic [21:0] rnm,
                                         input logic [21:0] rkm);
        logic [31:0]     lat1, lon1, lat2, lon2, dlat, dlon, rlon, hlat, hlon, c32;
        longint          s1, c1, s2, c2, shl, chl, shn, chn, sd, cd, sr, cr, a, half;
        longint unsigned sa, sb, rad;
        t_out            r;
        lat1 = p.from_lat;
        lon1 = p.from_lon;
        lat2 = p.to_lat;
        lon2 = p.to_lon;
        dlat = lat2 - lat1;
        dlon = lon2 - lon1;
        rlon = lon1 - lon2;
        hlat = 32'(to_signed(dlat) >>> 1);
        hlon = 32'(to_signed(dlon) >>> 1);
        rotate_sincos(lat1, s1, c1);
        rotate_sincos(lat2, s2, c2);
        rotate_sincos(hlat, shl, chl);
        rotate_sincos(hlon, shn, chn);
        rotate_sincos(dlon, sd, cd);
        rotate_sincos(rlon, sr, cr);
        a = q30_mul(shl, shl) + q30_mul(q30_mul(c1, c2), q30_mul(shn, shn));
        if (a < 0) a = 0;
        if (a > ONE_Q30) a = ONE_Q30;
        sa = floor_sqrt(longint'(a) << 30);
        sb = floor_sqrt(longint'(ONE_Q30 - a) << 30);
        half = to_signed(vector_angle(longint'(sa), longint'(sb)));
        if (half < 0) half = 0;
        if (half > QUARTER) half = QUARTER;
        c32 = 32'(2 * half);
        rad = (longint'(c32) * 64'd3373259426 + (64'd1 << 30)) >> 31;
        r.dist_nm_q8   = 22'(scale_radius(rnm, rad, 64'd4194303));
        r.dist_km_q8   = 23'(scale_radius(rkm, rad, 64'd8388607));
        r.bearing_fwd  = vector_angle(q30_mul(sd, c2),
                                      q30_mul(c1, s2) - q30_mul(q30_mul(s1, c2), cd));
        r.bearing_back = vector_angle(q30_mul(sr, c1),
                                      q30_mul(c2, s1) - q30_mul(q30_mul(s2, c1), cr));
        return r;
    endfunction

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    initial fail_count = 0;

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            radius_nm = RADIUS_NM_RST;
            radius_km = RADIUS_KM_RST;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_RADIUS_NM) radius_nm = i_cfg_wdata;
                else radius_km = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready)
                expected_results.insert(expected_results.size(),
                                        predict_leg(i_in, radius_nm, radius_km));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transfer: %p", i_out);
                end else begin
                    want = expected_results.pop_front();
                    if (want.dist_nm_q8 !== i_out.dist_nm_q8 ||
                        want.dist_km_q8 !== i_out.dist_km_q8 ||
                        want.bearing_fwd !== i_out.bearing_fwd ||
                        want.bearing_back !== i_out.bearing_back) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, i_out);
                    end
                end
            end
        end
    end
endmodule

// ===== verif/great_circle_distance_bearing_unit_tb.sv =====
// Testbench top of the great circle distance and bearing unit: stimulus, clock, reset, verdict
module great_circle_distance_bearing_unit_tb import gcdb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY     = 112;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                i_in_valid = 0;
    logic                o_in_ready;
    t_in                 i_in = '0;
    logic                o_out_valid;
    logic                i_out_ready = 0;
    t_out                o_out;
    logic                i_cfg_we = 0;
    t_reg_idx            i_cfg_index = REG_RADIUS_NM;
    logic [RADIUS_W-1:0] i_cfg_wdata = '0;
    int                  fail_count;
    int                  pending;
    int                  cycle_count = 0;
    bit                  hold_long = 0;
    bit                  no_idle = 0;

    always #5 i_clk = ~i_clk;

    great_circle_distance_bearing_unit DUT (.*);

    great_circle_distance_bearing_unit_checker checker_inst (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_in,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out(o_out),
        .i_cfg_we, .i_cfg_index, .i_cfg_wdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[great_circle_distance_bearing_unit] ERROR");
            $finish;
        end
    end

    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_out_ready <= 0;
                repeat (400) @(negedge i_clk);
                hold_long = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                i_out_ready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    task automatic send_leg(input logic [31:0] flat, input logic [31:0] flon,
                            input logic [31:0] tlat, input logic [31:0] tlon);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 0;
        end
        @(negedge i_clk);
        i_in_valid <= 1;
        i_in <= '{from_lat: flat, from_lon: flon, to_lat: tlat, to_lon: tlon};
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic write_radius(input t_reg_idx idx, input logic [RADIUS_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 0;
        wait (pending == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_lat();
        return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
    endfunction

    task automatic random_legs(input int n);
        logic [31:0] la, lo;
        int          kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            la = rand_lat();
            lo = $urandom;
            if (kind < 6)
                send_leg(la, lo, rand_lat(), $urandom);
            else if (kind == 6)
                send_leg(la, lo, la + $urandom_range(0, 2000) - 1000,
                         lo + $urandom_range(0, 2000) - 1000);
            else if (kind == 7)
                send_leg(la, lo, -la, lo + 32'h8000_0000);
            else if (kind == 8)
                send_leg(la, lo, la, lo);
            else
                send_leg($urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        send_leg(0, 0, 0, 0);
        send_leg(32'h4000_0000, 0, 32'hC000_0000, 0);
        send_leg(32'h4000_0000, 32'h1234_5678, 32'h4000_0000, 32'h8765_4321);
        send_leg(0, 32'h8000_0000, 0, 32'h7FFF_FFFF);
        send_leg(0, 0, 0, 32'h8000_0000);
        send_leg(32'h1000_0000, 32'h2000_0000, 32'hF000_0000, 32'hA000_0000);
        send_leg(0, 0, 32'h0000_0001, 0);
        send_leg(0, 0, 0, 32'h0000_0001);
        send_leg(32'h6000_0000, 0, 32'h9000_0000, 32'h4000_0000);
        send_leg(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_leg(32'hC000_0000, 32'h4000_0000, 32'h2000_0000, 32'hC000_0000);
        send_leg(32'h2000_0000, 0, 32'h2000_0000, 32'h4000_0000);
        random_legs(120);
        drain();

        write_radius(REG_RADIUS_NM, '1);
        write_radius(REG_RADIUS_KM, '1);
        send_leg(0, 0, 0, 32'h8000_0000);
        send_leg(32'h4000_0000, 0, 32'hC000_0000, 0);
        hold_long = 1;
        random_legs(120);
        drain();

        write_radius(REG_RADIUS_NM, '0);
        write_radius(REG_RADIUS_KM, '0);
        no_idle = 1;
        random_legs(120);
        no_idle = 0;
        drain();

        write_radius(REG_RADIUS_NM, RADIUS_W'($urandom));
        write_radius(REG_RADIUS_KM, RADIUS_W'($urandom));
        random_legs(120);
        drain();

        if (fail_count == 0)
            $display("[great_circle_distance_bearing_unit] OK");
        else
            $display("[great_circle_distance_bearing_unit] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gcdb_pkg.sv
hdl/gcdb_cordic.sv
hdl/great_circle_distance_bearing_unit.sv
hdl/gcdb_chk.sv
verif/great_circle_distance_bearing_unit_checker.sv
verif/great_circle_distance_bearing_unit_tb.sv
